// ----- hdl/retro_video_cell_renderer_top_assert.svh -----
// Assertion macros shared by the renderer RTL.
`ifndef RETRO_VIDEO_CELL_RENDERER_TOP_ASSERT_SVH
`define RETRO_VIDEO_CELL_RENDERER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define RVCR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("renderer check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define RVCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("renderer check failed: next-cycle implication");

`else

`define RVCR_ASSERT_SAME(label, clk, rst, ante, cons)
`define RVCR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/rvcr_pkg.sv -----
package rvcr_pkg;

   localparam int PIXELS_PER_CELL = 7;
   localparam logic [7:0] MIXED_SPLIT_LINE = 8'd160;
   localparam int RVCR_QUEUE_DEPTH = 2;

   localparam logic OP_SWITCH = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   // Bit positions in the mode flag register.
   localparam int FLAG_TEXT   = 0;
   localparam int FLAG_MIXED  = 1;
   localparam int FLAG_PAGE2  = 2;
   localparam int FLAG_HIRES  = 3;
   localparam int FLAG_ALTCH  = 4;
   localparam int FLAG_80COL  = 5;
   localparam int FLAG_DHIRES = 6;
   localparam logic [6:0] FLAGS_RESET = 7'h01;

   // Soft switch addresses.
   localparam logic [15:0] SW_80COL_OFF  = 16'hC00C;
   localparam logic [15:0] SW_80COL_ON   = 16'hC00D;
   localparam logic [15:0] SW_ALTCH_OFF  = 16'hC00E;
   localparam logic [15:0] SW_ALTCH_ON   = 16'hC00F;
   localparam logic [15:0] SW_RD_TEXT    = 16'hC01A;
   localparam logic [15:0] SW_RD_MIXED   = 16'hC01B;
   localparam logic [15:0] SW_RD_PAGE2   = 16'hC01C;
   localparam logic [15:0] SW_RD_HIRES   = 16'hC01D;
   localparam logic [15:0] SW_RD_ALTCH   = 16'hC01E;
   localparam logic [15:0] SW_RD_80COL   = 16'hC01F;
   localparam logic [15:0] SW_TEXT_OFF   = 16'hC050;
   localparam logic [15:0] SW_TEXT_ON    = 16'hC051;
   localparam logic [15:0] SW_MIXED_OFF  = 16'hC052;
   localparam logic [15:0] SW_MIXED_ON   = 16'hC053;
   localparam logic [15:0] SW_PAGE2_OFF  = 16'hC054;
   localparam logic [15:0] SW_PAGE2_ON   = 16'hC055;
   localparam logic [15:0] SW_HIRES_OFF  = 16'hC056;
   localparam logic [15:0] SW_HIRES_ON   = 16'hC057;
   localparam logic [15:0] SW_DHIRES_ON  = 16'hC05E;
   localparam logic [15:0] SW_DHIRES_OFF = 16'hC05F;
   localparam logic [15:0] SW_ID         = 16'hC07F;

   localparam logic [7:0] READ_FLAG_SET   = 8'h8D;
   localparam logic [7:0] READ_FLAG_CLEAR = 8'h0D;
   localparam logic [7:0] READ_ID         = 8'h7F;

   localparam logic [7:0] CODE_REMAP_A_IN  = 8'hDD;
   localparam logic [7:0] CODE_REMAP_A_OUT = 8'hFD;
   localparam logic [7:0] CODE_REMAP_B_IN  = 8'hDB;
   localparam logic [7:0] CODE_REMAP_B_OUT = 8'hFB;
   localparam logic [7:0] CODE_NORMAL_MIN  = 8'h40;
   localparam logic [7:0] CODE_FLASH_END   = 8'h80;

   localparam logic [15:0] TEXT_PAGE1_BASE  = 16'h0400;
   localparam logic [15:0] TEXT_PAGE2_BASE  = 16'h0800;
   localparam logic [15:0] HIRES_PAGE1_BASE = 16'h2000;
   localparam logic [15:0] HIRES_PAGE2_BASE = 16'h4000;
   localparam logic [15:0] ROW_GROUP_STRIDE = 16'h0080;
   localparam logic [15:0] THIRD_STRIDE     = 16'd40;
   localparam logic [15:0] HIRES_LINE_STRIDE = 16'h0400;

   localparam logic [15:0] RGB_WHITE = 16'hFFFF;
   localparam logic [15:0] RGB_BLACK = 16'h0000;

   // Drawing mode of a queued word.
   localparam logic [1:0] MODE_SWITCH = 2'd0;
   localparam logic [1:0] MODE_TEXT   = 2'd1;
   localparam logic [1:0] MODE_LORES  = 2'd2;
   localparam logic [1:0] MODE_HIRES  = 2'd3;

   typedef struct packed {
      logic        op;
      logic [15:0] access_address;
      logic [7:0]  scan_line;
      logic [5:0]  column;
      logic [7:0]  cell_byte;
      logic [7:0]  left_byte;
      logic [7:0]  right_byte;
      logic [7:0]  glyph_row;
      logic        flash_phase;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [15:0] fetch_address;
      logic [10:0] glyph_address;
      logic [15:0] pixel_0;
      logic [15:0] pixel_1;
      logic [15:0] pixel_2;
      logic [15:0] pixel_3;
      logic [15:0] pixel_4;
      logic [15:0] pixel_5;
      logic [15:0] pixel_6;
   } rsp_payload_type;

   typedef struct packed {
      logic char_remap_enable;
   } csr_payload_type;

   // Classified word handed from the front end to the back end.
   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] read_data;
      logic       page2;
      logic [7:0] scan_line;
      logic [5:0] column;
      logic [7:0] cell_byte;
      logic [7:0] left_byte;
      logic [7:0] right_byte;
      logic [7:0] glyph_row;
      logic       flash_phase;
   } cell_item_type;

   function automatic logic [7:0] flag_read(input logic flag);
      return flag ? READ_FLAG_SET : READ_FLAG_CLEAR;
   endfunction

   function automatic logic [15:0] lores_color(input logic [3:0] idx);
      logic [15:0] c;
      case (idx)
         4'd0:    c = 16'h0000;
         4'd1:    c = 16'hD806;
         4'd2:    c = 16'h0013;
         4'd3:    c = 16'hD91B;
         4'd4:    c = 16'h03A4;
         4'd5:    c = 16'h52AA;
         4'd6:    c = 16'h211F;
         4'd7:    c = 16'h655F;
         4'd8:    c = 16'h8AA0;
         4'd9:    c = 16'hFB20;
         4'd10:   c = 16'hAD55;
         4'd11:   c = 16'hFCD1;
         4'd12:   c = 16'h16E0;
         4'd13:   c = 16'hFFE0;
         4'd14:   c = 16'h47F3;
         default: c = 16'hFFFF;
      endcase
      return c;
   endfunction

   function automatic logic [15:0] hires_color(input logic [3:0] idx);
      logic [15:0] c;
      case (idx)
         4'd0:    c = 16'h0000;
         4'd1:    c = 16'hD91B;
         4'd2:    c = 16'h16E0;
         4'd3:    c = 16'h16E0;
         4'd4:    c = 16'hD91B;
         4'd5:    c = 16'h211F;
         4'd6:    c = 16'hFB20;
         4'd7:    c = 16'hFB20;
         4'd8:    c = 16'h211F;
         default: c = 16'hFFFF;
      endcase
      return c;
   endfunction

endpackage

// ----- hdl/rvcr_chan_if.sv -----
interface rvcr_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/rvcr_front.sv -----
module rvcr_front
   import rvcr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   rvcr_chan_if.sink     req_chan,
   rvcr_chan_if.sink     csr_chan,
   input  logic          queue_full,
   output logic          push_valid,
   output cell_item_type push_item
);

   logic [6:0]  mode_flags_ff;
   logic [6:0]  mode_flags_in;
   logic        remap_ff;
   logic [7:0]  read_data;
   logic [7:0]  code;
   logic        text_view;
   logic        accept;
   logic [1:0]  mode;

   assign req_chan.ready = !queue_full;
   assign csr_chan.ready = 1'b1;
   assign accept = req_chan.valid && req_chan.ready;

   // Switch decode: writes and reads act alike, so the address alone decides.
   always_comb begin
      mode_flags_in = mode_flags_ff;
      read_data = '0;
      case (req_chan.payload.access_address)
         SW_80COL_OFF:  mode_flags_in[FLAG_80COL] = 1'b0;
         SW_80COL_ON:   mode_flags_in[FLAG_80COL] = 1'b1;
         SW_ALTCH_OFF:  mode_flags_in[FLAG_ALTCH] = 1'b0;
         SW_ALTCH_ON:   mode_flags_in[FLAG_ALTCH] = 1'b1;
         SW_RD_TEXT:    read_data = flag_read(mode_flags_ff[FLAG_TEXT]);
         SW_RD_MIXED:   read_data = flag_read(mode_flags_ff[FLAG_MIXED]);
         SW_RD_PAGE2:   read_data = flag_read(mode_flags_ff[FLAG_PAGE2]);
         SW_RD_HIRES:   read_data = flag_read(mode_flags_ff[FLAG_HIRES]);
         SW_RD_ALTCH:   read_data = flag_read(mode_flags_ff[FLAG_ALTCH]);
         SW_RD_80COL:   read_data = flag_read(mode_flags_ff[FLAG_80COL]);
         SW_TEXT_OFF:   mode_flags_in[FLAG_TEXT] = 1'b0;
         SW_TEXT_ON:    mode_flags_in[FLAG_TEXT] = 1'b1;
         SW_MIXED_OFF:  mode_flags_in[FLAG_MIXED] = 1'b0;
         SW_MIXED_ON:   mode_flags_in[FLAG_MIXED] = 1'b1;
         SW_PAGE2_OFF:  mode_flags_in[FLAG_PAGE2] = 1'b0;
         SW_PAGE2_ON:   mode_flags_in[FLAG_PAGE2] = 1'b1;
         SW_HIRES_OFF:  mode_flags_in[FLAG_HIRES] = 1'b0;
         SW_HIRES_ON:   mode_flags_in[FLAG_HIRES] = 1'b1;
         SW_DHIRES_ON:  mode_flags_in[FLAG_DHIRES] = 1'b1;
         SW_DHIRES_OFF: mode_flags_in[FLAG_DHIRES] = 1'b0;
         SW_ID:         read_data = READ_ID;
         default: begin
         end
      endcase
   end

   // Mixed mode shows text on the lines from the split downward.
   always_comb begin
      text_view = mode_flags_ff[FLAG_TEXT] ||
                  (mode_flags_ff[FLAG_MIXED] &&
                   (req_chan.payload.scan_line >= MIXED_SPLIT_LINE));
      if (req_chan.payload.op == OP_SWITCH) begin
         mode = MODE_SWITCH;
      end else if (text_view) begin
         mode = MODE_TEXT;
      end else if (mode_flags_ff[FLAG_HIRES]) begin
         mode = MODE_HIRES;
      end else begin
         mode = MODE_LORES;
      end
   end

   always_comb begin
      code = req_chan.payload.cell_byte;
      if (remap_ff && (mode == MODE_TEXT)) begin
         if (code == CODE_REMAP_A_IN) begin
            code = CODE_REMAP_A_OUT;
         end else if (code == CODE_REMAP_B_IN) begin
            code = CODE_REMAP_B_OUT;
         end
      end
   end

   always_comb begin
      push_valid            = accept;
      push_item.mode        = mode;
      push_item.read_data   = (mode == MODE_SWITCH) ? read_data : 8'h00;
      push_item.page2       = mode_flags_ff[FLAG_PAGE2];
      push_item.scan_line   = req_chan.payload.scan_line;
      push_item.column      = req_chan.payload.column;
      push_item.cell_byte   = code;
      push_item.left_byte   = req_chan.payload.left_byte;
      push_item.right_byte  = req_chan.payload.right_byte;
      push_item.glyph_row   = req_chan.payload.glyph_row;
      push_item.flash_phase = req_chan.payload.flash_phase;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_flags_ff <= FLAGS_RESET;
         remap_ff <= 1'b0;
      end else begin
         if (accept && (req_chan.payload.op == OP_SWITCH)) begin
            mode_flags_ff <= mode_flags_in;
         end
         if (csr_chan.valid) begin
            remap_ff <= csr_chan.payload.char_remap_enable;
         end
      end
   end

endmodule

// ----- hdl/rvcr_queue.sv -----
module rvcr_queue
   import rvcr_pkg::*;
#(
   parameter int DEPTH = RVCR_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  cell_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output cell_item_type head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cell_item_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic do_push;
   logic do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push_valid && !full;
   assign do_pop = pop && !empty;
   assign head_item = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- hdl/rvcr_back.sv -----
module rvcr_back
   import rvcr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          empty,
   input  cell_item_type head_item,
   output logic          pop,
   rvcr_chan_if.source   rsp_chan
);

   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;
   logic            rsp_valid_ff;
   logic            take;
   logic [15:0]     base;
   logic [15:0]     page_offset;
   logic [7:0]      code;
   logic            inverse;
   logic [10:0]     hbits;
   logic [3:0]      hue_base;
   logic [3:0]      idx [PIXELS_PER_CELL];
   logic [15:0]     pix [PIXELS_PER_CELL];

   assign take = !rsp_valid_ff || rsp_chan.ready;
   assign pop = take && !empty;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign code = head_item.cell_byte;
   assign inverse = (code < CODE_NORMAL_MIN) ||
                    (head_item.flash_phase && (code < CODE_FLASH_END));
   // Eleven-bit window: two bits of the left byte, seven of this cell, two of the right.
   assign hbits = {head_item.right_byte[1:0], head_item.cell_byte[6:0],
                   head_item.left_byte[6:5]};
   assign hue_base = {head_item.cell_byte[7], head_item.column[0], 1'b0} + 4'd1;

   always_comb begin
      base = 16'(head_item.scan_line[5:3]) * ROW_GROUP_STRIDE +
             16'(head_item.scan_line[7:6]) * THIRD_STRIDE +
             16'(head_item.column);
      if (head_item.mode == MODE_HIRES) begin
         page_offset = (head_item.page2 ? HIRES_PAGE2_BASE : HIRES_PAGE1_BASE) +
                       16'(head_item.scan_line[2:0]) * HIRES_LINE_STRIDE;
      end else begin
         page_offset = head_item.page2 ? TEXT_PAGE2_BASE : TEXT_PAGE1_BASE;
      end
   end

   always_comb begin
      for (int i = 0; i < PIXELS_PER_CELL; i++) begin
         idx[i] = 4'd0;
         if (hbits[i + 2]) begin
            idx[i] = (hbits[i + 1] || hbits[i + 3]) ? 4'd9 : hue_base + 4'(i % 2);
         end else if (hbits[i + 1] && hbits[i + 3]) begin
            idx[i] = hue_base + 4'(1 - (i % 2));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < PIXELS_PER_CELL; i++) begin
         case (head_item.mode)
            MODE_TEXT:  pix[i] = (head_item.glyph_row[i] ^ inverse) ? RGB_WHITE : RGB_BLACK;
            MODE_LORES: pix[i] = lores_color(head_item.cell_byte[7:4]);
            MODE_HIRES: pix[i] = hires_color(idx[i]);
            default:    pix[i] = RGB_BLACK;
         endcase
      end
   end

   always_comb begin
      rsp_in.read_data = head_item.read_data;
      rsp_in.fetch_address = (head_item.mode == MODE_SWITCH) ? 16'h0000 : base + page_offset;
      rsp_in.glyph_address = (head_item.mode == MODE_TEXT) ?
                             {code, head_item.scan_line[2:0]} : 11'h000;
      rsp_in.pixel_0 = pix[0];
      rsp_in.pixel_1 = pix[1];
      rsp_in.pixel_2 = pix[2];
      rsp_in.pixel_3 = pix[3];
      rsp_in.pixel_4 = pix[4];
      rsp_in.pixel_5 = pix[5];
      rsp_in.pixel_6 = pix[6];
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= !empty;
      end
   end

endmodule

// ----- hdl/retro_video_cell_renderer_top.sv -----
// Path: an accepted word enters the queue, moves to the output register when the back end
// pops it, and is taken from there as a result word.
// Throughput: one word per cycle while the result channel is ready; the queue read port and
// output register each move one word a cycle.
// Reset: synchronous, active high; mode flags return to text only, character remap
// is cleared and the queue and output register are emptied.

`include "retro_video_cell_renderer_top_assert.svh"

module retro_video_cell_renderer_top
   import rvcr_pkg::*;
#(
   parameter int QUEUE_DEPTH = RVCR_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   rvcr_chan_if.sink   req_chan,
   rvcr_chan_if.sink   csr_chan,
   rvcr_chan_if.source rsp_chan
);

   // The front end owns the soft switches and the remap register. Every accepted
   // word is decoded against the flags as they stand at that moment, so a switch
   // access takes effect for the very next render word without any hazard logic.
   // The decoded word, carrying its drawing mode and page, goes into a short queue.
   logic          push_valid;
   cell_item_type push_item;
   logic          queue_full;
   logic          queue_empty;
   logic          pop;
   cell_item_type head_item;

   rvcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   // The queue decouples the two halves: the front keeps taking words while
   // the result side is stalled, until the queue fills.
   rvcr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head_item  (head_item)
   );

   // The back end computes the fetch address, the glyph address and the seven
   // pixels of the head word, and registers them as the result word.
   rvcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (queue_empty),
      .head_item (head_item),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

   // The front never pushes into a full queue.
   `RVCR_ASSERT_SAME(a_no_push_when_full, clock, reset, push_valid, !queue_full)

   // A word taken from the queue is presented as a result in the next cycle.
   `RVCR_ASSERT_NEXT(a_pop_gives_result, clock, reset, pop, rsp_chan.valid)

   // Switch results carry read data only; render results never carry read data.
   `RVCR_ASSERT_SAME(a_read_data_only_on_switch, clock, reset,
      rsp_chan.valid && (rsp_chan.payload.fetch_address != 16'h0000),
      rsp_chan.payload.read_data == 8'h00)

endmodule
